// File: design/tac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_pkg
// Widths and stage counts shared by the triangle area and closure pipeline.
// ----------------------------------------------------------------------------
package tac_pkg;

    localparam int COORD_BITS     = 16;
    localparam int LEN_FRAC_SHIFT = 16;

    // squared length, shifted up, padded to an even width for the root
    localparam int LEN_RAD_RAW    = 2 * COORD_BITS + 1 + LEN_FRAC_SHIFT;
    localparam int LEN_RAD_W      = LEN_RAD_RAW + (LEN_RAD_RAW % 2);
    localparam int LEN_W          = LEN_RAD_W / 2;
    localparam int LEN_SQ_STAGES  = LEN_W;
    localparam int LEN_LAT        = 3 + LEN_SQ_STAGES;

    // Heron product
    localparam int P_W            = LEN_W + 2;
    localparam int MAG_W          = LEN_W + 1;
    localparam int PA_W           = 2 * MAG_W;
    localparam int PB_W           = P_W + MAG_W;
    localparam int LIMB_W         = 27;
    localparam int PA_HI_W        = PA_W - LIMB_W;
    localparam int PB_HI_W        = PB_W - LIMB_W;
    localparam int Q_RAW          = PA_W + PB_W;
    localparam int Q_W            = Q_RAW + (Q_RAW % 2);
    localparam int HERON_LAT      = 5;

    localparam int ROOT_W         = Q_W / 2;
    localparam int AREA_SQ_STAGES = ROOT_W;
    localparam int AREA_W         = 31;
    localparam int AREA_SHIFT     = 18;

    localparam int PIPE_LAT       = LEN_LAT + HERON_LAT + AREA_SQ_STAGES;

    typedef logic signed [COORD_BITS-1:0] t_coord;

endpackage

// File: design/tac_len.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_len
// Segment length: |dx|,|dy|, squares, sum, then a one-bit-per-stage root.
// ----------------------------------------------------------------------------
module tac_len import tac_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  t_coord           i_start_x,
    input  t_coord           i_start_y,
    input  t_coord           i_end_x,
    input  t_coord           i_end_y,
    output logic [LEN_W-1:0] o_len
);

    logic signed [COORD_BITS:0] n_dx, n_dy;
    logic [COORD_BITS-1:0]      n_mx, n_my;
    logic [COORD_BITS-1:0]      r_mx, r_my;
    logic [2*COORD_BITS-1:0]    r_sx, r_sy;
    logic [LEN_RAD_W-1:0]       r_rad;
    logic [LEN_RAD_W-1:0]       r_x   [LEN_SQ_STAGES];
    logic [LEN_RAD_W-1:0]       r_res [LEN_SQ_STAGES];

    assign n_dx = $signed({i_end_x[COORD_BITS-1], i_end_x})
                - $signed({i_start_x[COORD_BITS-1], i_start_x});
    assign n_dy = $signed({i_end_y[COORD_BITS-1], i_end_y})
                - $signed({i_start_y[COORD_BITS-1], i_start_y});
    assign n_mx = n_dx[COORD_BITS] ? COORD_BITS'(-n_dx) : n_dx[COORD_BITS-1:0];
    assign n_my = n_dy[COORD_BITS] ? COORD_BITS'(-n_dy) : n_dy[COORD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx  <= n_mx;
            r_my  <= n_my;
            r_sx  <= r_mx * r_mx;
            r_sy  <= r_my * r_my;
            r_rad <= LEN_RAD_W'({({1'b0, r_sx} + {1'b0, r_sy}), LEN_FRAC_SHIFT'(0)});
        end
    end

    for (genvar j = 0; j < LEN_SQ_STAGES; j++) begin : g_sq
        localparam logic [LEN_RAD_W-1:0] BIT = LEN_RAD_W'(1) << (LEN_RAD_W - 2 - 2 * j);
        logic [LEN_RAD_W-1:0] w_xin, w_rin, w_t;
        logic                 w_ge;
        if (j == 0) begin : g_first
            assign w_xin = r_rad;
            assign w_rin = '0;
        end else begin : g_next
            assign w_xin = r_x[j-1];
            assign w_rin = r_res[j-1];
        end
        assign w_t  = w_rin + BIT;
        assign w_ge = w_xin >= w_t;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[j]   <= w_ge ? w_xin - w_t : w_xin;
                r_res[j] <= w_ge ? (w_rin >> 1) + BIT : w_rin >> 1;
            end
        end
    end

    assign o_len = r_res[LEN_SQ_STAGES-1][LEN_W-1:0];

endmodule

// File: design/tac_heron.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_heron
// Perimeter and the three side factors, sign/zero clamp, and the exact
// product P*(b+c-a)*(a+c-b)*(a+b-c) built from 27-bit limb products.
// ----------------------------------------------------------------------------
module tac_heron import tac_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [LEN_W-1:0] i_a,
    input  logic [LEN_W-1:0] i_b,
    input  logic [LEN_W-1:0] i_c,
    output logic [Q_W-1:0]   o_q
);

    logic [P_W-1:0]         r_p1;
    logic [P_W-1:0]         r_f [3];
    logic [P_W-1:0]         r_p2;
    logic [MAG_W-1:0]       r_m [3];
    logic                   r_k2, r_k3, r_k4;
    logic [PA_W-1:0]        r_pa;
    logic [PB_W-1:0]        r_pb;
    logic [2*LIMB_W-1:0]    r_pp00;
    logic [LIMB_W+PB_HI_W-1:0]   r_pp01;
    logic [PA_HI_W+LIMB_W-1:0]   r_pp10;
    logic [PA_HI_W+PB_HI_W-1:0]  r_pp11;
    logic [Q_W-1:0]         r_q;
    logic [MAG_W-1:0]       n_m [3];
    logic [2:0]             n_z, n_s;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s[i] = r_f[i][P_W-1];
            n_z[i] = (r_f[i] == '0);
            n_m[i] = n_s[i] ? MAG_W'(-r_f[i]) : MAG_W'(r_f[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= P_W'(i_a) + P_W'(i_b) + P_W'(i_c);
            r_f[0] <= P_W'(i_b) + P_W'(i_c) - P_W'(i_a);
            r_f[1] <= P_W'(i_a) + P_W'(i_c) - P_W'(i_b);
            r_f[2] <= P_W'(i_a) + P_W'(i_b) - P_W'(i_c);

            r_p2   <= r_p1;
            r_m    <= n_m;
            r_k2   <= (|n_z) | (^n_s);

            r_pa   <= r_m[0] * r_m[1];
            r_pb   <= r_p2 * r_m[2];
            r_k3   <= r_k2;

            r_pp00 <= r_pa[LIMB_W-1:0] * r_pb[LIMB_W-1:0];
            r_pp01 <= r_pa[LIMB_W-1:0] * r_pb[PB_W-1:LIMB_W];
            r_pp10 <= r_pa[PA_W-1:LIMB_W] * r_pb[LIMB_W-1:0];
            r_pp11 <= r_pa[PA_W-1:LIMB_W] * r_pb[PB_W-1:LIMB_W];
            r_k4   <= r_k3;

            r_q    <= r_k4 ? '0
                    : Q_W'(r_pp00)
                    + ((Q_W'(r_pp01) + Q_W'(r_pp10)) << LIMB_W)
                    + (Q_W'(r_pp11) << (2 * LIMB_W));
        end
    end

    assign o_q = r_q;

    // factors that survive the clamp are nonzero, so their product is too
    a_pa_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && !r_k2 |=> r_pa != '0)
        else $error("nonzero factors gave zero product");

    a_kill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_k4 |=> r_q == '0)
        else $error("clamped item left nonzero radicand");

endmodule

// File: design/tac_asqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_asqrt
// Root of the Heron product, one result bit per stage.
// ----------------------------------------------------------------------------
module tac_asqrt import tac_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [Q_W-1:0]    i_q,
    output logic [ROOT_W-1:0] o_root
);

    logic [Q_W-1:0] r_x   [AREA_SQ_STAGES];
    logic [Q_W-1:0] r_res [AREA_SQ_STAGES];

    for (genvar j = 0; j < AREA_SQ_STAGES; j++) begin : g_sq
        localparam logic [Q_W-1:0] BIT = Q_W'(1) << (Q_W - 2 - 2 * j);
        logic [Q_W-1:0] w_xin, w_rin, w_t;
        logic           w_ge;
        if (j == 0) begin : g_first
            assign w_xin = i_q;
            assign w_rin = '0;
        end else begin : g_next
            assign w_xin = r_x[j-1];
            assign w_rin = r_res[j-1];
        end
        assign w_t  = w_rin + BIT;
        assign w_ge = w_xin >= w_t;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[j]   <= w_ge ? w_xin - w_t : w_xin;
                r_res[j] <= w_ge ? (w_rin >> 1) + BIT : w_rin >> 1;
            end
        end
    end

    assign o_root = r_res[AREA_SQ_STAGES-1][ROOT_W-1:0];

endmodule

// File: design/triangle_area_and_closure.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_area_and_closure
// Closure test of three segments and their Heron area, fully pipelined.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   input   | in        | i_valid / o_stall    | i_s1..s3 start/end x/y, Q8.8
//   output  | out       | o_valid / i_stall    | o_area, o_closes_triangle
//
// One beat per cycle in and out while the output beat is not stalled. Three
// length stages, 25 length-root stages, five product stages, 53 area-root
// stages and the output register make up the pipe. Reset clears only the valid
// bits. The whole pipe holds while the output beat is stalled; empty slots do
// not advance separately.
// ----------------------------------------------------------------------------
module triangle_area_and_closure import tac_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_coord            i_s1_start_x,
    input  t_coord            i_s1_start_y,
    input  t_coord            i_s1_end_x,
    input  t_coord            i_s1_end_y,
    input  t_coord            i_s2_start_x,
    input  t_coord            i_s2_start_y,
    input  t_coord            i_s2_end_x,
    input  t_coord            i_s2_end_y,
    input  t_coord            i_s3_start_x,
    input  t_coord            i_s3_start_y,
    input  t_coord            i_s3_end_x,
    input  t_coord            i_s3_end_y,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [AREA_W-1:0] o_area,
    output logic              o_closes_triangle
);

    logic                w_en;
    logic [PIPE_LAT-1:0] r_v;
    logic [PIPE_LAT-1:0] r_cl;
    logic                r_o_valid;
    logic [AREA_W-1:0]   r_area;
    logic                r_closes;
    logic [LEN_W-1:0]    w_len_a, w_len_b, w_len_c;
    logic [Q_W-1:0]      w_q;
    logic [ROOT_W-1:0]   w_root;
    logic                n_closes;
    logic                n_sat;
    logic [AREA_W-1:0]   n_area;

    function automatic logic same(input t_coord px, input t_coord py,
                                  input t_coord qx, input t_coord qy);
        return (px == qx) && (py == qy);
    endfunction

    assign w_en    = !(r_o_valid && i_stall);
    assign o_stall = !w_en;

    tac_len u_len_a (
        .i_clk(i_clk), .i_en(w_en),
        .i_start_x(i_s1_start_x), .i_start_y(i_s1_start_y),
        .i_end_x(i_s1_end_x), .i_end_y(i_s1_end_y), .o_len(w_len_a)
    );
    tac_len u_len_b (
        .i_clk(i_clk), .i_en(w_en),
        .i_start_x(i_s2_start_x), .i_start_y(i_s2_start_y),
        .i_end_x(i_s2_end_x), .i_end_y(i_s2_end_y), .o_len(w_len_b)
    );
    tac_len u_len_c (
        .i_clk(i_clk), .i_en(w_en),
        .i_start_x(i_s3_start_x), .i_start_y(i_s3_start_y),
        .i_end_x(i_s3_end_x), .i_end_y(i_s3_end_y), .o_len(w_len_c)
    );

    tac_heron u_heron (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(w_len_a), .i_b(w_len_b), .i_c(w_len_c), .o_q(w_q)
    );

    tac_asqrt u_asqrt (
        .i_clk(i_clk), .i_en(w_en), .i_q(w_q), .o_root(w_root)
    );

    // a = start, b = end of each segment
    assign n_closes =
        (same(i_s1_start_x, i_s1_start_y, i_s2_start_x, i_s2_start_y) &&
         same(i_s2_end_x,   i_s2_end_y,   i_s3_end_x,   i_s3_end_y)   &&
         same(i_s3_start_x, i_s3_start_y, i_s1_end_x,   i_s1_end_y))  ||
        (same(i_s1_start_x, i_s1_start_y, i_s2_end_x,   i_s2_end_y)   &&
         same(i_s2_start_x, i_s2_start_y, i_s3_end_x,   i_s3_end_y)   &&
         same(i_s3_start_x, i_s3_start_y, i_s1_end_x,   i_s1_end_y))  ||
        (same(i_s1_start_x, i_s1_start_y, i_s2_start_x, i_s2_start_y) &&
         same(i_s2_end_x,   i_s2_end_y,   i_s3_start_x, i_s3_start_y) &&
         same(i_s3_end_x,   i_s3_end_y,   i_s1_end_x,   i_s1_end_y))  ||
        (same(i_s1_start_x, i_s1_start_y, i_s2_end_x,   i_s2_end_y)   &&
         same(i_s2_start_x, i_s2_start_y, i_s3_start_x, i_s3_start_y) &&
         same(i_s3_end_x,   i_s3_end_y,   i_s1_end_x,   i_s1_end_y))  ||
        (same(i_s1_end_x,   i_s1_end_y,   i_s2_start_x, i_s2_start_y) &&
         same(i_s2_end_x,   i_s2_end_y,   i_s3_end_x,   i_s3_end_y)   &&
         same(i_s3_start_x, i_s3_start_y, i_s1_start_x, i_s1_start_y)) ||
        (same(i_s1_end_x,   i_s1_end_y,   i_s2_end_x,   i_s2_end_y)   &&
         same(i_s2_start_x, i_s2_start_y, i_s3_end_x,   i_s3_end_y)   &&
         same(i_s3_start_x, i_s3_start_y, i_s1_start_x, i_s1_start_y)) ||
        (same(i_s1_end_x,   i_s1_end_y,   i_s2_start_x, i_s2_start_y) &&
         same(i_s2_end_x,   i_s2_end_y,   i_s3_start_x, i_s3_start_y) &&
         same(i_s3_end_x,   i_s3_end_y,   i_s1_start_x, i_s1_start_y)) ||
        (same(i_s1_end_x,   i_s1_end_y,   i_s2_end_x,   i_s2_end_y)   &&
         same(i_s2_start_x, i_s2_start_y, i_s3_start_x, i_s3_start_y) &&
         same(i_s3_end_x,   i_s3_end_y,   i_s1_start_x, i_s1_start_y));

    assign n_sat  = |w_root[ROOT_W-1:AREA_SHIFT+AREA_W];
    assign n_area = n_sat ? '1 : w_root[AREA_SHIFT+AREA_W-1:AREA_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= '0;
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_v       <= {r_v[PIPE_LAT-2:0], i_valid};
            r_o_valid <= r_v[PIPE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cl     <= {r_cl[PIPE_LAT-2:0], n_closes};
            r_closes <= r_cl[PIPE_LAT-1];
            r_area   <= n_area;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_area            = r_area;
    assign o_closes_triangle = r_closes;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held output beat");

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_v) && $stable(r_cl))
        else $error("pipeline moved during stall");

    a_pipe_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |=> r_v[0] == $past(i_valid) && r_o_valid == $past(r_v[PIPE_LAT-1]))
        else $error("valid bit lost or invented");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the triangle closure and Heron area pipeline.
// Directed corner triangles, then random closed, near-closed and noise
// segment sets. Random sender gaps and receiver stalls are applied in phases.
// Every output beat is checked against a local model in arrival order.
// ----------------------------------------------------------------------------
module testbench import tac_pkg::*;;

    typedef struct {
        t_coord c[12];
        bit     drain;
    } t_seg_set;

    typedef struct {
        logic [AREA_W-1:0] area;
        logic              closes;
    } t_tri_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              o_valid;
    logic              i_stall;
    logic [AREA_W-1:0] o_area;
    logic              o_closes_triangle;
    t_coord            drv[12];

    t_seg_set          pending_sets[$];
    t_tri_result       expected_results[$];
    t_seg_set          cur_set;
    int                errors;
    int                idle_pct;
    int                stall_pct;

    triangle_area_and_closure u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_s1_start_x      (drv[0]),
        .i_s1_start_y      (drv[1]),
        .i_s1_end_x        (drv[2]),
        .i_s1_end_y        (drv[3]),
        .i_s2_start_x      (drv[4]),
        .i_s2_start_y      (drv[5]),
        .i_s2_end_x        (drv[6]),
        .i_s2_end_y        (drv[7]),
        .i_s3_start_x      (drv[8]),
        .i_s3_start_y      (drv[9]),
        .i_s3_end_x        (drv[10]),
        .i_s3_end_y        (drv[11]),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_area            (o_area),
        .o_closes_triangle (o_closes_triangle)
    );

    function automatic bit [63:0] int_sqrt(bit [127:0] x);
        bit [127:0] r;
        bit [127:0] t;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            t = r | (128'd1 << i);
            if (t * t <= x) r = t;
        end
        return r[63:0];
    endfunction

    function automatic longint seg_length(t_seg_set s, int k);
        longint dx;
        longint dy;
        dx = longint'(s.c[k+2]) - longint'(s.c[k]);
        dy = longint'(s.c[k+3]) - longint'(s.c[k+1]);
        return longint'(int_sqrt(128'((dx * dx + dy * dy) << 16)));
    endfunction

    function automatic bit pt_eq(t_seg_set s, int p, int q);
        return s.c[p] == s.c[q] && s.c[p+1] == s.c[q+1];
    endfunction

    function automatic t_tri_result triangle_predict(t_seg_set s);
        t_tri_result r;
        longint      len[3];
        longint      f[3];
        int          neg;
        bit          zero;
        bit [127:0]  q;
        bit [63:0]   root;
        // point offsets: a1=0 b1=2 a2=4 b2=6 a3=8 b3=10
        r.closes =
            (pt_eq(s, 0, 4) && pt_eq(s, 6, 10) && pt_eq(s, 8, 2)) ||
            (pt_eq(s, 0, 6) && pt_eq(s, 4, 10) && pt_eq(s, 8, 2)) ||
            (pt_eq(s, 0, 4) && pt_eq(s, 6, 8)  && pt_eq(s, 10, 2)) ||
            (pt_eq(s, 0, 6) && pt_eq(s, 4, 8)  && pt_eq(s, 10, 2)) ||
            (pt_eq(s, 2, 4) && pt_eq(s, 6, 10) && pt_eq(s, 8, 0)) ||
            (pt_eq(s, 2, 6) && pt_eq(s, 4, 10) && pt_eq(s, 8, 0)) ||
            (pt_eq(s, 2, 4) && pt_eq(s, 6, 8)  && pt_eq(s, 10, 0)) ||
            (pt_eq(s, 2, 6) && pt_eq(s, 4, 8)  && pt_eq(s, 10, 0));
        for (int i = 0; i < 3; i++) len[i] = seg_length(s, 4 * i);
        f[0] = len[1] + len[2] - len[0];
        f[1] = len[0] + len[2] - len[1];
        f[2] = len[0] + len[1] - len[2];
        q    = 128'(len[0] + len[1] + len[2]);
        neg  = 0;
        zero = 0;
        for (int i = 0; i < 3; i++) begin
            if (f[i] == 0) zero = 1;
            if (f[i] < 0) begin
                neg++;
                q = q * 128'(-f[i]);
            end else begin
                q = q * 128'(f[i]);
            end
        end
        if (zero || neg % 2 == 1) begin
            r.area = '0;
        end else begin
            root   = int_sqrt(q) >> AREA_SHIFT;
            r.area = (root > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : root[AREA_W-1:0];
        end
        return r;
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 5))
            0:       return t_coord'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
            1, 2:    return t_coord'($urandom_range(0, 2047)) - t_coord'(1024);
            default: return t_coord'($urandom());
        endcase
    endfunction

    task automatic add_seg(ref t_seg_set s, input int k, input t_coord px, py, qx, qy,
                           input bit flip);
        if (flip) begin
            s.c[k] = qx; s.c[k+1] = qy; s.c[k+2] = px; s.c[k+3] = py;
        end else begin
            s.c[k] = px; s.c[k+1] = py; s.c[k+2] = qx; s.c[k+3] = qy;
        end
    endtask

    task automatic push_triangle(t_coord ax, ay, bx, by, cx, cy, bit [2:0] orient);
        t_seg_set s;
        s.drain = 0;
        add_seg(s, 0, ax, ay, bx, by, orient[0]);
        add_seg(s, 4, ax, ay, cx, cy, orient[1]);
        add_seg(s, 8, cx, cy, bx, by, orient[2]);
        // swapping segment one exercises the patterns joined at its end point
        pending_sets.push_back(s);
    endtask

    task automatic push_flat(t_coord v);
        t_seg_set s;
        s.drain = 0;
        foreach (s.c[k]) s.c[k] = v;
        pending_sets.push_back(s);
    endtask

    initial begin
        i_clk   = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_stall = 0;
        foreach (drv[k]) drv[k] = '0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("testbench failed");
        $finish;
    end

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(triangle_predict(cur_set));
            end
            if (!i_valid || !o_stall) begin
                if (pending_sets.size() > 0 && $urandom_range(0, 99) >= idle_pct &&
                    !(pending_sets[0].drain &&
                      (expected_results.size() > 0 || (i_valid && !o_stall)))) begin
                    cur_set = pending_sets.pop_front();
                    foreach (drv[k]) drv[k] <= cur_set.c[k];
                    i_valid <= 1;
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        t_tri_result e;
        i_stall <= i_rst_n && ($urandom_range(0, 99) < stall_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected output beat: area %0d closes %0d", o_area,
                       o_closes_triangle);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_area !== e.area) begin
                    $error("area: expected %0d actual %0d", e.area, o_area);
                    errors++;
                end
                if (o_closes_triangle !== e.closes) begin
                    $error("closes_triangle: expected %0d actual %0d", e.closes,
                           o_closes_triangle);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_seg_set s;
        int       n;
        errors     = 0;
        idle_pct   = 0;
        stall_pct  = 0;

        push_flat(16'sh0000);
        push_flat(16'sh7FFF);
        push_flat(-16'sh8000);
        push_triangle(0, 0, 16'sh0300, 0, 0, 16'sh0400, 3'b000);
        for (int o = 1; o < 8; o++)
            push_triangle(16'sh0100, -16'sh0200, 16'sh0500, 16'sh0100, -16'sh0300,
                          16'sh0600, 3'(o));
        push_triangle(-16'sh8000, -16'sh8000, 16'sh7FFF, -16'sh8000,
                      -16'sh8000, 16'sh7FFF, 3'b000);
        push_triangle(-16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF,
                      16'sh7FFF, -16'sh8000, 3'b101);
        push_triangle(-16'sh8000, 16'sh7FFF, 16'sh7FFF, -16'sh8000,
                      16'sh7FFF, 16'sh7FFF, 3'b010);
        // collinear, degenerate segment, tiny triangle
        push_triangle(0, 0, 16'sh0200, 16'sh0200, 16'sh0400, 16'sh0400, 3'b000);
        push_triangle(16'sh0010, 16'sh0010, 16'sh0010, 16'sh0010, 16'sh0500, 0, 3'b001);
        push_triangle(0, 0, 1, 0, 0, 1, 3'b000);
        foreach (s.c[k]) s.c[k] = t_coord'(16'h5555 ^ {16{k[0]}});
        s.drain = 0;
        pending_sets.push_back(s);
        foreach (s.c[k]) s.c[k] = t_coord'($urandom());
        pending_sets.push_back(s);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        n = 0;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            for (int i = 0; i < 68; i++) begin
                if ($urandom_range(0, 9) < 7) begin
                    push_triangle(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                  rand_coord(), rand_coord(), 3'($urandom()));
                    if ($urandom_range(0, 4) == 0) begin
                        s = pending_sets.pop_back();
                        s.c[$urandom_range(0, 11)] += ($urandom_range(0, 1) ? 1 : -1);
                        pending_sets.push_back(s);
                    end
                end else begin
                    s.drain = 0;
                    foreach (s.c[k]) s.c[k] = rand_coord();
                    pending_sets.push_back(s);
                end
                n++;
                if (n == 300) begin
                    s = pending_sets.pop_back();
                    s.drain = 1;
                    pending_sets.push_back(s);
                end
            end
            while (pending_sets.size() > 40) @(posedge i_clk);
        end

        while (pending_sets.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (PIPE_LAT + 20) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
